>>> rtl/vlb_pkg.sv
// Shared types and constants for the voxel level binning block.
// No dependencies.
package vlb_pkg;

  localparam int MAX_LEVELS_DEF = 8;
  localparam int LVL_W  = 4;   // holds a level count up to 15
  localparam int QW     = 10;  // widest cell index the parameter range allows
  localparam int AXES   = 3;

  localparam logic [2:0] REG_MIN_X    = 3'd0;
  localparam logic [2:0] REG_MIN_Y    = 3'd1;
  localparam logic [2:0] REG_MIN_Z    = 3'd2;
  localparam logic [2:0] REG_EXT_X    = 3'd3;
  localparam logic [2:0] REG_EXT_Y    = 3'd4;
  localparam logic [2:0] REG_EXT_Z    = 3'd5;
  localparam logic [2:0] REG_LEVELS   = 3'd6;

  typedef struct packed {
    logic                          vld;
    logic [15:0]                   tag;
    logic signed [33:0]            longest;
    logic [30:0]                   axis_ext;
    logic [LVL_W-1:0]              levels;
    logic [34:0]                   fit_min;
    logic [LVL_W-1:0]              best;
    logic [AXES-1:0][31:0]         e2;
    logic [AXES-1:0][33:0]         rem;
    logic [AXES-1:0][QW-1:0]       q;
    logic [AXES-1:0]               sat;
    logic [AXES-1:0]               zero;
  } item_t;

endpackage

>>> rtl/vlb_in_if.sv
// Input channel: one object box and tag per beat.
// Standalone interface.
interface vlb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;
  logic [15:0]        object_tag;
  modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, object_tag, input ready);
  modport sink   (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, object_tag, output ready);
endinterface

>>> rtl/vlb_out_if.sv
// Result channel: level, cell indices and linear address per beat.
// Standalone interface.
interface vlb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tag_out;
  logic [2:0]  grid_level;
  logic [6:0]  cell_x;
  logic [6:0]  cell_y;
  logic [6:0]  cell_z;
  logic [20:0] cell_address;
  modport source (output valid, tag_out, grid_level, cell_x, cell_y, cell_z, cell_address,
                  input ready);
  modport sink   (input valid, tag_out, grid_level, cell_x, cell_y, cell_z, cell_address,
                  output ready);
endinterface

>>> rtl/vlb_cfg_if.sv
// Configuration write channel: register index and data per beat.
// Standalone interface.
interface vlb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/voxel_level_binning.sv
// Voxel level binning top level: input stage, fit cell row, division cell row, output.
// Depends on vlb_pkg, the channel interfaces, vlb_fit_cell and vlb_div_cell.
//
// Takes one object box per cycle, back to back, while the output is not stalled, and
// returns one result per box, in order. A result beat is presented through
// 2*MAX_LEVELS+1 register stages: one input stage, a row of MAX_LEVELS cells
// that each test one grid level's fit, a row of MAX_LEVELS-1 cells that each produce
// one bit of the three cell indices, and the output register. The whole row advances
// whenever the output register is empty or its beat is taken, so in_ch.ready follows
// out_ch.ready. Configuration writes are always taken and must only be issued while
// no box is in flight.
module voxel_level_binning #(
  parameter int MAX_LEVELS = vlb_pkg::MAX_LEVELS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  vlb_in_if.sink    in_ch,
  vlb_out_if.source out_ch,
  vlb_cfg_if.sink   cfg_ch
);
  import vlb_pkg::*;

  logic signed [31:0] smin_r [AXES];
  logic [30:0]        sext_r [AXES];
  logic [3:0]         levels_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        smin_r[a] <= '0;
        sext_r[a] <= '0;
      end
      levels_r <= 4'd1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MIN_X:  smin_r[0] <= cfg_ch.data;
        REG_MIN_Y:  smin_r[1] <= cfg_ch.data;
        REG_MIN_Z:  smin_r[2] <= cfg_ch.data;
        REG_EXT_X:  sext_r[0] <= cfg_ch.data[30:0];
        REG_EXT_Y:  sext_r[1] <= cfg_ch.data[30:0];
        REG_EXT_Z:  sext_r[2] <= cfg_ch.data[30:0];
        REG_LEVELS: levels_r  <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // input stage
  item_t              a_r, a_nxt;
  logic signed [32:0] side [AXES];
  logic signed [32:0] sum  [AXES];
  logic signed [33:0] ctr  [AXES];
  logic signed [31:0] bmin [AXES];
  logic signed [31:0] bmax [AXES];

  always_comb begin
    bmin[0] = in_ch.box_min_x; bmin[1] = in_ch.box_min_y; bmin[2] = in_ch.box_min_z;
    bmax[0] = in_ch.box_max_x; bmax[1] = in_ch.box_max_y; bmax[2] = in_ch.box_max_z;
    a_nxt          = '0;
    a_nxt.vld      = in_ch.valid;
    a_nxt.tag      = in_ch.object_tag;
    for (int a = 0; a < AXES; a++) begin
      side[a] = 33'(bmax[a]) - 33'(bmin[a]);
      sum[a]  = 33'(bmax[a]) + 33'(bmin[a]);
      ctr[a]  = 34'(sum[a]) - {smin_r[a][31], smin_r[a], 1'b0};
      a_nxt.e2[a]   = {sext_r[a], 1'b0};
      a_nxt.rem[a]  = ctr[a];
      a_nxt.zero[a] = (sext_r[a] == '0) || (ctr[a] <= 34'sd0);
      a_nxt.sat[a]  = ctr[a] >= $signed({2'b0, sext_r[a], 1'b0});
    end
    a_nxt.longest  = 34'(side[0]);
    a_nxt.axis_ext = sext_r[0];
    if (side[1] > side[0]) begin
      a_nxt.longest  = 34'(side[1]);
      a_nxt.axis_ext = sext_r[1];
    end
    if (34'(side[2]) > a_nxt.longest) begin
      a_nxt.longest  = 34'(side[2]);
      a_nxt.axis_ext = sext_r[2];
    end
    if (levels_r == '0) a_nxt.levels = LVL_W'(1);
    else if (levels_r > LVL_W'(MAX_LEVELS)) a_nxt.levels = LVL_W'(MAX_LEVELS);
    else a_nxt.levels = levels_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
    end else if (en) begin
      a_r <= a_nxt;
    end
  end

  item_t fc [MAX_LEVELS+1];
  item_t dc [MAX_LEVELS];
  assign fc[0] = a_r;
  assign dc[0] = fc[MAX_LEVELS];

  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_fit
    vlb_fit_cell #(.IDX(k)) u_fit (
      .clk(clk), .rst_n(rst_n), .en(en), .d_in(fc[k]), .d_out(fc[k+1])
    );
  end

  for (genvar k = 0; k < MAX_LEVELS-1; k++) begin : g_div
    vlb_div_cell #(.IDX(k)) u_div (
      .clk(clk), .rst_n(rst_n), .en(en), .d_in(dc[k]), .d_out(dc[k+1])
    );
  end

  // output stage
  item_t       f;
  logic [QW-1:0] mask;
  logic [QW-1:0] cidx [AXES];
  logic [20:0] addr_nxt;
  logic [15:0] tag_r;
  logic [2:0]  lvl_r;
  logic [6:0]  cx_r, cy_r, cz_r;
  logic [20:0] addr_r;

  always_comb begin
    f    = dc[MAX_LEVELS-1];
    mask = QW'((QW'(1) << f.best) - QW'(1));
    for (int a = 0; a < AXES; a++) begin
      if (f.zero[a]) cidx[a] = '0;
      else if (f.sat[a]) cidx[a] = mask;
      else cidx[a] = f.q[a];
    end
    addr_nxt = (21'(cidx[2]) << {f.best, 1'b0}) + (21'(cidx[1]) << f.best) + 21'(cidx[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= f.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r  <= f.tag;
      lvl_r  <= f.best[2:0];
      cx_r   <= cidx[0][6:0];
      cy_r   <= cidx[1][6:0];
      cz_r   <= cidx[2][6:0];
      addr_r <= addr_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.tag_out      = tag_r;
  assign out_ch.grid_level   = lvl_r;
  assign out_ch.cell_x       = cx_r;
  assign out_ch.cell_y       = cy_r;
  assign out_ch.cell_z       = cz_r;
  assign out_ch.cell_address = addr_r;
endmodule

>>> rtl/vlb_fit_cell.sv
// One level of the fit search: compares this level's voxel fit with the best so far.
// Depends on vlb_pkg.
module vlb_fit_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  vlb_pkg::item_t d_in,
  output vlb_pkg::item_t d_out
);
  import vlb_pkg::*;

  item_t              d_r, d_nxt;
  logic [30:0]        voxel;
  logic signed [34:0] diff;
  logic [34:0]        fit;

  always_comb begin
    voxel = d_in.axis_ext >> IDX;
    diff  = $signed({4'b0, voxel}) - 35'(d_in.longest);
    fit   = diff[34] ? 35'(-diff) : 35'(diff);
    d_nxt = d_in;
    if (LVL_W'(IDX) < d_in.levels && (IDX == 0 || fit < d_in.fit_min)) begin
      d_nxt.fit_min = fit;
      d_nxt.best    = LVL_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;
endmodule

>>> rtl/vlb_div_cell.sv
// One quotient bit of the cell index division on all three axes.
// Depends on vlb_pkg.
module vlb_div_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  vlb_pkg::item_t d_in,
  output vlb_pkg::item_t d_out
);
  import vlb_pkg::*;

  item_t       d_r, d_nxt;
  logic [34:0] r2 [AXES];
  logic        ge [AXES];

  always_comb begin
    d_nxt = d_in;
    for (int a = 0; a < AXES; a++) begin
      r2[a] = {d_in.rem[a], 1'b0};
      ge[a] = r2[a] >= {3'b0, d_in.e2[a]};
      if (LVL_W'(IDX) < d_in.best) begin
        d_nxt.rem[a] = ge[a] ? 34'(r2[a] - {3'b0, d_in.e2[a]}) : 34'(r2[a]);
        d_nxt.q[a]   = {d_in.q[a][QW-2:0], ge[a]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;
endmodule
